>>> hw/rtl/gec_pkg.sv
// Shared constants, types and register codes for the gaze eye-contact detector.
package gec_pkg;

	localparam int HIST_DEPTH = 6;
	localparam int GAZE_W     = 16;
	localparam int SUM_W      = GAZE_W + $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int IDX_W      = $clog2(HIST_DEPTH);
	localparam int OUT_CNT_W  = 5;

	// divider retires two quotient bits per cycle
	localparam int DIV_STEPS  = (SUM_W + 1) / 2;
	localparam int DIV_W      = 2 * DIV_STEPS;
	localparam int DSTEP_W    = $clog2(DIV_STEPS);

	// squarer operand and product widths
	localparam int SQ_IN_W    = GAZE_W + 1;
	localparam int SQ_W       = 2 * SQ_IN_W;
	localparam int ACC_W      = SQ_W + 1;

	localparam int LIM_W      = 33;
	localparam int MINI_W     = 5;
	localparam int ANG_W      = 15;
	localparam int BLINK_W    = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 33;

	localparam logic [LIM_W-1:0]   INLIER_DIST_SQ_RST  = LIM_W'(6553600);
	localparam logic [MINI_W-1:0]  MIN_INLIERS_RST     = MINI_W'(3);
	localparam logic [LIM_W-1:0]   CONTACT_DIST_SQ_RST = LIM_W'(4194304);
	localparam logic [ANG_W-1:0]   PITCH_LIMIT_RST     = ANG_W'(6434);
	localparam logic [ANG_W-1:0]   YAW_LIMIT_RST       = ANG_W'(6434);
	localparam logic [BLINK_W-1:0] BLINK_THRESHOLD_RST = BLINK_W'(748);
	localparam logic [LIM_W-1:0]   NEAR_DIST_SQ_RST    = LIM_W'(490000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INLIER_DIST_SQ  = 3'd0,
		REG_MIN_INLIERS     = 3'd1,
		REG_CONTACT_DIST_SQ = 3'd2,
		REG_PITCH_LIMIT     = 3'd3,
		REG_YAW_LIMIT       = 3'd4,
		REG_BLINK_THRESHOLD = 3'd5,
		REG_NEAR_DIST_SQ    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAZE_W-1:0] lr;
		logic signed [GAZE_W-1:0] ud;
	} point_t;

	typedef struct packed {
		logic en;
		logic load;
	} chain_ctrl_t;

endpackage

>>> hw/rtl/gec_cell.sv
// One history cell: holds a gaze point and passes it on when the row moves.
module gec_cell import gec_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  point_t d,
	output point_t q
);

	point_t pt_q;

	// take the neighbor's point on every move of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= '0;
		end else if (en) begin
			pt_q <= d;
		end
	end

	assign q = pt_q;

endmodule

>>> hw/rtl/gec_chain.sv
// Row of history cells: shifts in a new gaze point or rotates the ring.
module gec_chain import gec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  chain_ctrl_t ctrl,
	input  point_t      new_pt,
	output point_t      head
);

	point_t cell_d [HIST_DEPTH];
	point_t cell_q [HIST_DEPTH];

	// first cell takes the new point on load, otherwise the last cell wraps around
	assign cell_d[0] = ctrl.load ? new_pt : cell_q[HIST_DEPTH-1];

	genvar gi;
	generate
		for (gi = 1; gi < HIST_DEPTH; gi++) begin : g_link
			assign cell_d[gi] = cell_q[gi-1];
		end
		for (gi = 0; gi < HIST_DEPTH; gi++) begin : g_cell
			gec_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (ctrl.en),
				.d      (cell_d[gi]),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	assign head = cell_q[HIST_DEPTH-1];

endmodule

>>> hw/rtl/gec_div.sv
// Iterative signed divider by a small unsigned divisor, two quotient bits a cycle.
module gec_div import gec_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output logic signed [SUM_W-1:0] quotient
);

	logic [DIV_W-1:0]   work_q;
	logic [DIV_W-1:0]   work_n;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   rem_n;
	logic [CNT_W:0]     trial;
	logic [CNT_W-1:0]   dvsr_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;
	logic [DSTEP_W-1:0] step_q;
	logic [SUM_W-1:0]   mag;
	logic [SUM_W-1:0]   q_mag;

	// magnitude of the dividend; truncation toward zero restores the sign at the end
	assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

	// two restoring steps
	always_comb begin
		rem_n  = rem_q;
		work_n = work_q;
		trial  = '0;
		for (int k = 0; k < 2; k++) begin
			trial  = {rem_n, work_n[DIV_W-1]};
			work_n = {work_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvsr_q}) begin
				rem_n     = CNT_W'(trial - {1'b0, dvsr_q});
				work_n[0] = 1'b1;
			end else begin
				rem_n = trial[CNT_W-1:0];
			end
		end
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DSTEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold the operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= DIV_W'(mag);
			rem_q  <= '0;
			dvsr_q <= divisor;
			neg_q  <= dividend[SUM_W-1];
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign q_mag    = work_q[SUM_W-1:0];
	assign quotient = neg_q ? -$signed(q_mag) : $signed(q_mag);
	assign done     = done_q;

endmodule

>>> hw/rtl/gaze_eye_contact_detector.sv
// Gaze eye-contact detector top level: history row, squarers, dividers and sequencer.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------------
//  in      | in_valid / in_stall       | gaze_left_right, gaze_up_down, head_pitch,
//          |                           | head_yaw, blink_left, blink_right, pos_x/y/z
//  out     | out_valid / out_stall     | eye_contact, inlier_count
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  From acceptance to the result register, one request makes two passes around the cell
//  row and two runs of the bit-pair divider. One request is in work at a time; in_stall is
//  high from acceptance until the result is loaded.
//  A finished result waits in the output register while the next request is taken.
//  Reset clears the history to zero points and loads the register defaults.
module gaze_eye_contact_detector import gec_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [15:0]       gaze_left_right,
	input  logic signed [15:0]       gaze_up_down,
	input  logic signed [15:0]       head_pitch,
	input  logic signed [15:0]       head_yaw,
	input  logic [BLINK_W-1:0]       blink_left,
	input  logic [BLINK_W-1:0]       blink_right,
	input  logic signed [15:0]       pos_x,
	input  logic signed [15:0]       pos_y,
	input  logic signed [15:0]       pos_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     eye_contact,
	output logic [OUT_CNT_W-1:0]     inlier_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_SUM      = 11'b000_0000_0010,
		S_AVG_GO   = 11'b000_0000_0100,
		S_AVG_WAIT = 11'b000_0000_1000,
		S_DIST     = 11'b000_0001_0000,
		S_DRAIN    = 11'b000_0010_0000,
		S_INL_GO   = 11'b000_0100_0000,
		S_INL_WAIT = 11'b000_1000_0000,
		S_MAG      = 11'b001_0000_0000,
		S_CHK      = 11'b010_0000_0000,
		S_FINAL    = 11'b100_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		TAG_NONE   = 3'd0,
		TAG_POS_XY = 3'd1,
		TAG_POS_Z  = 3'd2,
		TAG_DIST   = 3'd3,
		TAG_MAG    = 3'd4
	} sq_tag_t;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] fill_q;
	logic accept;

	// registers
	logic [LIM_W-1:0]   inlier_dist_sq_q;
	logic [MINI_W-1:0]  min_inliers_q;
	logic [LIM_W-1:0]   contact_dist_sq_q;
	logic [ANG_W-1:0]   pitch_limit_q;
	logic [ANG_W-1:0]   yaw_limit_q;
	logic [BLINK_W-1:0] blink_threshold_q;
	logic [LIM_W-1:0]   near_dist_sq_q;

	// per-request flags and operands
	logic filled_q, cone_q, blink_q, near_ok_q, mag_ok_q;
	logic signed [GAZE_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [SUM_W-1:0]  sum_lr_q, sum_ud_q;
	logic signed [SUM_W-1:0]  isum_lr_q, isum_ud_q;
	logic signed [GAZE_W-1:0] avg_lr_q, avg_ud_q;
	logic signed [GAZE_W-1:0] inl_lr_q, inl_ud_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [ACC_W-1:0]         near_acc_q;

	// squarer stage
	logic signed [SQ_IN_W-1:0] sq_a_in, sq_b_in;
	logic signed [SQ_W-1:0]    prod_a, prod_b;
	logic [SQ_W-1:0]           sq_a_s1, sq_b_s1;
	sq_tag_t                   tag_n, tag_s1;
	point_t                    head_s1;
	logic [ACC_W-1:0]          sq_sum;

	// output register
	logic                 out_valid_q;
	logic                 eye_contact_q;
	logic [OUT_CNT_W-1:0] inlier_count_q;
	logic                 contact;

	// history row and dividers
	chain_ctrl_t chain_ctrl;
	point_t      new_pt, head;
	logic        div_start, done_lr, done_ud;
	logic signed [SUM_W-1:0] div_a_lr, div_a_ud, q_lr, q_ud;
	logic [CNT_W-1:0] div_b;

	logic [GAZE_W:0] abs_pitch, abs_yaw;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inlier_dist_sq_q  <= INLIER_DIST_SQ_RST;
			min_inliers_q     <= MIN_INLIERS_RST;
			contact_dist_sq_q <= CONTACT_DIST_SQ_RST;
			pitch_limit_q     <= PITCH_LIMIT_RST;
			yaw_limit_q       <= YAW_LIMIT_RST;
			blink_threshold_q <= BLINK_THRESHOLD_RST;
			near_dist_sq_q    <= NEAR_DIST_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INLIER_DIST_SQ:  inlier_dist_sq_q  <= cfg_data[LIM_W-1:0];
				REG_MIN_INLIERS:     min_inliers_q     <= cfg_data[MINI_W-1:0];
				REG_CONTACT_DIST_SQ: contact_dist_sq_q <= cfg_data[LIM_W-1:0];
				REG_PITCH_LIMIT:     pitch_limit_q     <= cfg_data[ANG_W-1:0];
				REG_YAW_LIMIT:       yaw_limit_q       <= cfg_data[ANG_W-1:0];
				REG_BLINK_THRESHOLD: blink_threshold_q <= cfg_data[BLINK_W-1:0];
				REG_NEAR_DIST_SQ:    near_dist_sq_q    <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// history row moves on load and during both passes
	assign new_pt.lr       = gaze_left_right;
	assign new_pt.ud       = gaze_up_down;
	assign chain_ctrl.load = accept;
	assign chain_ctrl.en   = accept || (state_q == S_SUM) || (state_q == S_DIST);

	gec_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (chain_ctrl),
		.new_pt (new_pt),
		.head   (head)
	);

	// dividers: full average by the depth, inlier average by the count
	assign div_start = (state_q == S_AVG_GO) || (state_q == S_INL_GO);
	assign div_a_lr  = (state_q == S_AVG_GO) ? sum_lr_q : isum_lr_q;
	assign div_a_ud  = (state_q == S_AVG_GO) ? sum_ud_q : isum_ud_q;
	assign div_b     = (state_q == S_AVG_GO) ? CNT_W'(HIST_DEPTH) : cnt_q;

	gec_div u_div_lr (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a_lr),
		.divisor  (div_b),
		.done     (done_lr),
		.quotient (q_lr)
	);

	gec_div u_div_ud (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a_ud),
		.divisor  (div_b),
		.done     (done_ud),
		.quotient (q_ud)
	);

	// head angle magnitudes
	assign abs_pitch = head_pitch[GAZE_W-1] ? (GAZE_W+1)'(-{head_pitch[GAZE_W-1], head_pitch})
	                                        : {1'b0, head_pitch};
	assign abs_yaw   = head_yaw[GAZE_W-1] ? (GAZE_W+1)'(-{head_yaw[GAZE_W-1], head_yaw})
	                                      : {1'b0, head_yaw};

	// select squarer operands by phase
	always_comb begin
		sq_a_in = '0;
		sq_b_in = '0;
		tag_n   = TAG_NONE;
		if (state_q == S_SUM && idx_q == IDX_W'(0)) begin
			sq_a_in = {pos_x_q[GAZE_W-1], pos_x_q};
			sq_b_in = {pos_y_q[GAZE_W-1], pos_y_q};
			tag_n   = TAG_POS_XY;
		end else if (state_q == S_SUM && idx_q == IDX_W'(1)) begin
			sq_a_in = {pos_z_q[GAZE_W-1], pos_z_q};
			tag_n   = TAG_POS_Z;
		end else if (state_q == S_DIST) begin
			sq_a_in = {head.lr[GAZE_W-1], head.lr} - {avg_lr_q[GAZE_W-1], avg_lr_q};
			sq_b_in = {head.ud[GAZE_W-1], head.ud} - {avg_ud_q[GAZE_W-1], avg_ud_q};
			tag_n   = TAG_DIST;
		end else if (state_q == S_MAG) begin
			sq_a_in = {inl_lr_q[GAZE_W-1], inl_lr_q};
			sq_b_in = {inl_ud_q[GAZE_W-1], inl_ud_q};
			tag_n   = TAG_MAG;
		end
	end

	assign prod_a = sq_a_in * sq_a_in;
	assign prod_b = sq_b_in * sq_b_in;

	// register squares with their tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= TAG_NONE;
		end else begin
			tag_s1 <= tag_n;
		end
	end

	always_ff @(posedge clk) begin
		sq_a_s1 <= unsigned'(prod_a);
		sq_b_s1 <= unsigned'(prod_b);
		head_s1 <= head;
	end

	assign sq_sum = ACC_W'(sq_a_s1) + ACC_W'(sq_b_s1);

	// consume squares: position near check, head distance, inlier marking, average magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == S_SUM) begin
			cnt_q <= '0;
		end else if (tag_s1 == TAG_DIST && sq_sum < ACC_W'(inlier_dist_sq_q)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			isum_lr_q <= '0;
			isum_ud_q <= '0;
		end
		case (tag_s1)
			TAG_POS_XY: near_acc_q <= sq_sum;
			TAG_POS_Z:  near_ok_q  <= (near_acc_q + sq_sum) < ACC_W'(near_dist_sq_q);
			TAG_DIST: begin
				if (sq_sum < ACC_W'(inlier_dist_sq_q)) begin
					isum_lr_q <= isum_lr_q + SUM_W'(head_s1.lr);
					isum_ud_q <= isum_ud_q + SUM_W'(head_s1.ud);
				end
			end
			TAG_MAG:    mag_ok_q   <= sq_sum < ACC_W'(contact_dist_sq_q);
			default: ;
		endcase
	end

	// latch request operands, sum the row and take the divider quotients
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q  <= pos_x;
			pos_y_q  <= pos_y;
			pos_z_q  <= pos_z;
			cone_q   <= (abs_pitch < {2'b00, pitch_limit_q}) &&
			            (abs_yaw < {2'b00, yaw_limit_q});
			blink_q  <= (blink_left < blink_threshold_q) ||
			            (blink_right < blink_threshold_q);
			filled_q <= (fill_q == CNT_W'(HIST_DEPTH));
			sum_lr_q <= '0;
			sum_ud_q <= '0;
		end else if (state_q == S_SUM) begin
			sum_lr_q <= sum_lr_q + SUM_W'(head.lr);
			sum_ud_q <= sum_ud_q + SUM_W'(head.ud);
		end
		if (state_q == S_AVG_WAIT && done_lr && done_ud) begin
			avg_lr_q <= q_lr[GAZE_W-1:0];
			avg_ud_q <= q_ud[GAZE_W-1:0];
		end
		if (state_q == S_INL_WAIT && done_lr && done_ud) begin
			inl_lr_q <= q_lr[GAZE_W-1:0];
			inl_ud_q <= q_ud[GAZE_W-1:0];
		end
	end

	assign contact = (OUT_CNT_W'(cnt_q) > min_inliers_q) && mag_ok_q && filled_q &&
	                 cone_q && blink_q && near_ok_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= S_SUM;
						if (fill_q != CNT_W'(HIST_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_SUM: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(HIST_DEPTH - 1)) begin
						state_q <= S_AVG_GO;
					end
				end
				S_AVG_GO: state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (done_lr && done_ud) begin
						idx_q   <= '0;
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(HIST_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN:  state_q <= S_INL_GO;
				S_INL_GO: state_q <= S_INL_WAIT;
				S_INL_WAIT: begin
					if (done_lr && done_ud) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: state_q <= S_CHK;
				S_CHK: state_q <= S_FINAL;
				S_FINAL: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINAL && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINAL && (!out_valid_q || !out_stall)) begin
			eye_contact_q  <= contact;
			inlier_count_q <= OUT_CNT_W'(cnt_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign eye_contact  = eye_contact_q;
	assign inlier_count = inlier_count_q;

endmodule

>>> hw/rtl/gec_checker.sv
// Port-level checks for the gaze eye-contact detector, bound to the top level.
module gec_checker import gec_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 eye_contact,
	input logic [OUT_CNT_W-1:0] inlier_count
);

	// one request in work at a time: stall right after acceptance
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in work");

	// count never exceeds the history depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inlier_count <= OUT_CNT_W'(HIST_DEPTH))
		else $error("inlier count above history depth");

	// contact needs at least one inlier
	a_contact_needs_inlier: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && eye_contact |-> inlier_count != '0)
		else $error("eye contact reported with no inliers");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(eye_contact) &&
		$stable(inlier_count))
		else $error("stalled result changed");

endmodule

bind gaze_eye_contact_detector gec_checker u_gec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.eye_contact  (eye_contact),
	.inlier_count (inlier_count)
);
